### rtl/nppl_pkg.sv
// shared constants for the nearest point and path length unit
package nppl_pkg;

  localparam int COORD_BITS     = 16;
  localparam int MAX_POINTS     = 1024;
  localparam int FRACTION_BITS  = 8;

  // squared distances: two squares of (COORD_BITS+1)-bit differences
  localparam int SQ_BITS        = 35;
  localparam int SQ_PAIRS       = (SQ_BITS + 1) / 2;

  localparam int INDEX_BITS     = 10;
  localparam int DIST_BITS      = 26;
  localparam int LEN_BITS       = 36;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  localparam int MIN_RUN_POINTS = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUERY_X = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUERY_Y = 1'd1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_SHORT   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_DROPPED = 2'd2;

endpackage

### rtl/nppl_if.sv
// point and result channel interfaces
interface nppl_point_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [nppl_pkg::COORD_BITS-1:0] point_x;
  logic signed [nppl_pkg::COORD_BITS-1:0] point_y;
  logic                                   last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface nppl_result_if;
  logic                                    valid;
  logic                                    ready;
  logic        [nppl_pkg::INDEX_BITS-1:0]  nearest_index;
  logic signed [nppl_pkg::COORD_BITS-1:0]  nearest_x;
  logic signed [nppl_pkg::COORD_BITS-1:0]  nearest_y;
  logic        [nppl_pkg::DIST_BITS-1:0]   nearest_distance;
  logic        [nppl_pkg::LEN_BITS-1:0]    total_length;
  logic        [nppl_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, nearest_index, nearest_x, nearest_y, nearest_distance,
                  total_length, status, input ready);
  modport sink   (input valid, nearest_index, nearest_x, nearest_y, nearest_distance,
                  total_length, status, output ready);
endinterface

### rtl/nppl_root.sv
// restoring square root, one result bit per cycle
module nppl_root #(
  parameter int FRACTION_BITS = nppl_pkg::FRACTION_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [nppl_pkg::SQ_BITS-1:0]                  value,
  output logic                                          done,
  output logic [nppl_pkg::SQ_PAIRS+FRACTION_BITS-1:0]   root
);

  localparam int RW = nppl_pkg::SQ_PAIRS + FRACTION_BITS;
  localparam int VW = 2 * nppl_pkg::SQ_PAIRS;
  localparam int CW = $clog2(RW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] val;
  logic [RW+1:0] rem;
  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          fits;

  // bring down the next bit pair; zeros once the value is used up
  assign rem_sh = {rem[RW-1:0], val[VW-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(RW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= VW'(value);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= val << 2;
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[RW-2:0], fits};
    end
  end

endmodule

### rtl/nearest_point_and_path_length_unit.sv
// top level: nearest point search and polyline length over a run of points
//
// Points of a run arrive one beat at a time on the points channel and are
// measured against the query point held in two configuration registers
// (index 0 query_x, index 1 query_y). The unit keeps the point with the
// smallest exact squared distance to the query (earlier point wins a tie) and
// sums the floor square roots of the segment lengths between consecutive
// points, all lengths carrying FRACTION_BITS fraction bits. The beat marked
// last_point closes the run and produces one result beat; all run state then
// returns to its reset value. Points past MAX_POINTS are dropped and flagged
// in status. Everything runs through one 17x17 squarer and one bit-serial
// square root, so the unit takes a point only while idle: the first point of
// a run is only squared and compared, every later point also sends its
// segment length through the square root, and the last point adds a further
// root for the nearest distance. A finished result sits in an output
// register, so the next run can start while it waits to be taken.
module nearest_point_and_path_length_unit #(
  parameter int MAX_POINTS    = nppl_pkg::MAX_POINTS,
  parameter int FRACTION_BITS = nppl_pkg::FRACTION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [nppl_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [nppl_pkg::COORD_BITS-1:0]        cfg_data,
  nppl_point_if.sink                             points,
  nppl_result_if.source                          result
);

  localparam int C     = nppl_pkg::COORD_BITS;
  localparam int SQW   = nppl_pkg::SQ_BITS;
  localparam int RW    = nppl_pkg::SQ_PAIRS + FRACTION_BITS;
  localparam int LW    = nppl_pkg::LEN_BITS;
  localparam int DB    = nppl_pkg::DIST_BITS;
  localparam int IB    = nppl_pkg::INDEX_BITS;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DW    = (RW > DB) ? RW : DB;
  localparam int XW    = (IDX_W > IB) ? IDX_W : IB;

  // sequencer states
  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,  // waiting for a point
    S_DQX  = 12'b000000000010,  // square x offset to query
    S_DQY  = 12'b000000000100,  // square y offset to query
    S_QSUM = 12'b000000001000,  // add the two squares
    S_UPD  = 12'b000000010000,  // nearest point compare and update
    S_DPX  = 12'b000000100000,  // square x step from previous point
    S_DPY  = 12'b000001000000,  // square y step from previous point
    S_PSUM = 12'b000010000000,  // add squares, launch segment root
    S_SEG  = 12'b000100000000,  // wait for segment root, accumulate
    S_FIN  = 12'b001000000000,  // retire point, launch distance root on last
    S_DIST = 12'b010000000000,  // wait for distance root
    S_DONE = 12'b100000000000   // hand result to the output register
  } state_t;

  state_t state, state_next;

  // configuration
  logic signed [C-1:0] query_x, query_y;

  // current point
  logic signed [C-1:0] cur_x, cur_y;
  logic                cur_last;
  logic                cur_drop;

  // run state
  logic [CNT_W-1:0]    point_count;
  logic signed [C-1:0] previous_x, previous_y;
  logic [SQW-1:0]      best_square;
  logic [IDX_W-1:0]    best_index;
  logic signed [C-1:0] best_x, best_y;
  logic [LW-1:0]       length_sum;
  logic                dropped_flag;

  // shared squarer
  logic signed [C:0]   diff;
  logic [C:0]          mag;
  logic [2*C+1:0]      prod;
  logic [SQW-1:0]      sq;
  logic [SQW-1:0]      sq_sum;

  // shared root
  logic                root_start;
  logic [SQW-1:0]      root_value;
  logic                root_done;
  logic [RW-1:0]       root;

  logic                count_full;
  logic [LW:0]         len_add;
  logic [DW-1:0]       root_ext;
  logic [DB-1:0]       near_dist;
  logic [XW-1:0]       index_ext;
  logic [nppl_pkg::STATUS_BITS-1:0] status_val;

  // result register
  logic                res_valid;
  logic [IB-1:0]       res_index;
  logic signed [C-1:0] res_x, res_y;
  logic [DB-1:0]       res_dist;
  logic [LW-1:0]       res_len;
  logic [nppl_pkg::STATUS_BITS-1:0] res_status;

  logic                in_beat;
  logic                res_free;

  assign points.ready = (state == S_IDLE);
  assign in_beat      = points.valid && points.ready;
  assign res_free     = !res_valid || result.ready;
  assign count_full   = point_count >= CNT_W'(MAX_POINTS);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        nppl_pkg::REG_QUERY_X: query_x <= cfg_data;
        nppl_pkg::REG_QUERY_Y: query_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // squarer operand follows the sequencer
  always_comb begin
    case (state)
      S_DQX:   diff = {cur_x[C-1], cur_x} - {query_x[C-1], query_x};
      S_DQY:   diff = {cur_y[C-1], cur_y} - {query_y[C-1], query_y};
      S_DPX:   diff = {cur_x[C-1], cur_x} - {previous_x[C-1], previous_x};
      S_DPY:   diff = {cur_y[C-1], cur_y} - {previous_y[C-1], previous_y};
      default: diff = '0;
    endcase
  end

  assign mag    = diff[C] ? (C+1)'(-diff) : (C+1)'(diff);
  assign sq_sum = sq + SQW'(prod);

  always_ff @(posedge clk) begin
    prod <= mag * mag;
  end

  // root launches: segment length after the step squares, distance at run end
  assign root_start = (state == S_PSUM) || ((state == S_FIN) && cur_last);
  assign root_value = (state == S_PSUM) ? sq_sum : best_square;

  nppl_root #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (root_value),
    .done  (root_done),
    .root  (root)
  );

  // saturating length accumulate
  assign len_add = {1'b0, length_sum} + (LW+1)'(root);

  // distance clamp and result fields
  assign root_ext  = DW'(root);
  assign near_dist = (root_ext > DW'(nppl_pkg::DIST_MAX)) ? nppl_pkg::DIST_MAX
                                                          : root_ext[DB-1:0];
  assign index_ext = XW'(best_index);

  always_comb begin
    if (dropped_flag) begin
      status_val = nppl_pkg::ST_DROPPED;
    end else if (point_count < CNT_W'(nppl_pkg::MIN_RUN_POINTS)) begin
      status_val = nppl_pkg::ST_SHORT;
    end else begin
      status_val = nppl_pkg::ST_OK;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_beat) begin
          state_next = count_full ? S_FIN : S_DQX;
        end
      end
      S_DQX:  state_next = S_DQY;
      S_DQY:  state_next = S_QSUM;
      S_QSUM: state_next = S_UPD;
      S_UPD:  state_next = (point_count != '0) ? S_DPX : S_FIN;
      S_DPX:  state_next = S_DPY;
      S_DPY:  state_next = S_PSUM;
      S_PSUM: state_next = S_SEG;
      S_SEG: begin
        if (root_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN:  state_next = cur_last ? S_DIST : S_IDLE;
      S_DIST: begin
        if (root_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the point
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cur_x    <= points.point_x;
      cur_y    <= points.point_y;
      cur_last <= points.last_point;
      cur_drop <= count_full;
    end
  end

  // squared distance accumulator
  always_ff @(posedge clk) begin
    case (state)
      S_DQY, S_DPY:  sq <= SQW'(prod);
      S_QSUM, S_PSUM: sq <= sq_sum;
      default: ;
    endcase
  end

  // run state, cleared on reset and when the result is handed over
  always_ff @(posedge clk) begin
    if (rst || ((state == S_DONE) && res_free)) begin
      point_count  <= '0;
      previous_x   <= '0;
      previous_y   <= '0;
      best_square  <= '1;
      best_index   <= '0;
      best_x       <= '0;
      best_y       <= '0;
      length_sum   <= '0;
      dropped_flag <= 1'b0;
    end else begin
      if (in_beat && count_full) begin
        dropped_flag <= 1'b1;
      end
      // first point of a run always wins; later ones only if strictly nearer
      if ((state == S_UPD) && ((point_count == '0) || (sq < best_square))) begin
        best_square <= sq;
        best_index  <= point_count[IDX_W-1:0];
        best_x      <= cur_x;
        best_y      <= cur_y;
      end
      if ((state == S_SEG) && root_done) begin
        length_sum <= len_add[LW] ? '1 : len_add[LW-1:0];
      end
      if ((state == S_FIN) && !cur_drop) begin
        previous_x  <= cur_x;
        previous_y  <= cur_y;
        point_count <= point_count + CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_DONE) && res_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && res_free) begin
      res_index  <= index_ext[IB-1:0];
      res_x      <= best_x;
      res_y      <= best_y;
      res_dist   <= near_dist;
      res_len    <= length_sum;
      res_status <= status_val;
    end
  end

  assign result.valid            = res_valid;
  assign result.nearest_index    = res_index;
  assign result.nearest_x        = res_x;
  assign result.nearest_y        = res_y;
  assign result.nearest_distance = res_dist;
  assign result.total_length     = res_len;
  assign result.status           = res_status;

endmodule

### rtl/nppl_checker.sv
// port-level checks for the nearest point and path length unit, with bind
module nppl_port_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [nppl_pkg::LEN_BITS-1:0]          out_total_length,
  input logic [nppl_pkg::STATUS_BITS-1:0]       out_status
);

  // after every point beat, ready is low in the following cycle
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("point taken on consecutive cycles");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == nppl_pkg::ST_OK) || (out_status == nppl_pkg::ST_SHORT) ||
                  (out_status == nppl_pkg::ST_DROPPED))
    else $error("undefined status code");

  // a run of one point has no segments
  a_short_no_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == nppl_pkg::ST_SHORT) |-> out_total_length == '0)
    else $error("single point run with nonzero length");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_point_and_path_length_unit nppl_port_checker u_nppl_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (points.valid),
  .in_ready         (points.ready),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .out_total_length (result.total_length),
  .out_status       (result.status)
);

### tb/nppl_checker.sv
// checker: rebuilds each run summary from the point beats it sees and compares the result beats
module nppl_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [nppl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [nppl_pkg::COORD_BITS-1:0]     cfg_data,
  nppl_point_if                               points,
  nppl_result_if                              result,
  output int                                  mismatches,
  output int                                  summaries_due,
  output int                                  points_taken,
  output int                                  summaries_taken
);
  import nppl_pkg::*;

  localparam logic [63:0] LEN_CEIL = (64'd1 << LEN_BITS) - 1;
  localparam logic [63:0] SQ_CEIL  = (64'd1 << SQ_BITS) - 1;

  typedef struct {
    logic [INDEX_BITS-1:0]        near_idx;
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic [DIST_BITS-1:0]         near_dist;
    logic [LEN_BITS-1:0]          path_len;
    logic [STATUS_BITS-1:0]       run_status;
  } run_summary_t;

  run_summary_t due_summaries[$];

  logic signed [COORD_BITS-1:0] query_x, query_y;
  logic signed [COORD_BITS-1:0] prev_x, prev_y, best_x, best_y;
  logic [63:0]                  best_sq, len_sum;
  int                           run_len, best_idx;
  bit                           dropped;

  function automatic logic [63:0] sq_gap(input logic signed [COORD_BITS-1:0] a,
                                         input logic signed [COORD_BITS-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  // floor(sqrt(sq) * 2^FRACTION_BITS), one result bit per trial
  function automatic logic [63:0] scaled_sqrt(input logic [63:0] sq);
    logic [63:0] n, r, c;
    n = sq << (2 * FRACTION_BITS);
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic void clear_run();
    run_len  = 0;
    prev_x   = '0;
    prev_y   = '0;
    best_sq  = SQ_CEIL;
    best_idx = 0;
    best_x   = '0;
    best_y   = '0;
    len_sum  = '0;
    dropped  = 1'b0;
  endfunction

  function automatic void fold_point(input logic signed [COORD_BITS-1:0] x,
                                     input logic signed [COORD_BITS-1:0] y,
                                     input logic last);
    logic [63:0]  sq, seg, root;
    run_summary_t s;
    if (run_len >= MAX_POINTS) begin
      dropped = 1'b1;
    end else begin
      sq = sq_gap(x, query_x) + sq_gap(y, query_y);
      // first point always wins, later ones only when strictly nearer
      if (run_len == 0 || sq < best_sq) begin
        best_sq  = sq;
        best_idx = run_len;
        best_x   = x;
        best_y   = y;
      end
      if (run_len > 0) begin
        seg = scaled_sqrt(sq_gap(x, prev_x) + sq_gap(y, prev_y));
        if (seg > LEN_CEIL - len_sum) len_sum = LEN_CEIL;
        else len_sum = len_sum + seg;
      end
      prev_x  = x;
      prev_y  = y;
      run_len = run_len + 1;
    end
    if (last) begin
      root = scaled_sqrt(best_sq);
      if (root > DIST_MAX) root = DIST_MAX;
      s.near_idx  = INDEX_BITS'(best_idx);
      s.near_x    = best_x;
      s.near_y    = best_y;
      s.near_dist = root[DIST_BITS-1:0];
      s.path_len  = len_sum[LEN_BITS-1:0];
      if (dropped) s.run_status = ST_DROPPED;
      else if (run_len < MIN_RUN_POINTS) s.run_status = ST_SHORT;
      else s.run_status = ST_OK;
      due_summaries.push_back(s);
      clear_run();
    end
  endfunction

  task automatic report(input string msg);
    if (mismatches < 100) $display("mismatch: %s", msg);
    mismatches = mismatches + 1;
  endtask

  task automatic check_summary();
    run_summary_t want;
    if (due_summaries.size() == 0) begin
      report($sformatf("result beat %0d arrived with no run closed", summaries_taken));
    end else begin
      want = due_summaries.pop_front();
      if (result.nearest_index !== want.near_idx)
        report($sformatf("beat %0d nearest_index got %0d want %0d", summaries_taken,
                         result.nearest_index, want.near_idx));
      if (result.nearest_x !== want.near_x)
        report($sformatf("beat %0d nearest_x got %0d want %0d", summaries_taken,
                         result.nearest_x, want.near_x));
      if (result.nearest_y !== want.near_y)
        report($sformatf("beat %0d nearest_y got %0d want %0d", summaries_taken,
                         result.nearest_y, want.near_y));
      if (result.nearest_distance !== want.near_dist)
        report($sformatf("beat %0d nearest_distance got %0h want %0h", summaries_taken,
                         result.nearest_distance, want.near_dist));
      if (result.total_length !== want.path_len)
        report($sformatf("beat %0d total_length got %0h want %0h", summaries_taken,
                         result.total_length, want.path_len));
      if (result.status !== want.run_status)
        report($sformatf("beat %0d status got %0d want %0d", summaries_taken,
                         result.status, want.run_status));
    end
    summaries_taken = summaries_taken + 1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      query_x = '0;
      query_y = '0;
      clear_run();
      due_summaries.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_QUERY_X: query_x = cfg_data;
          REG_QUERY_Y: query_y = cfg_data;
          default: ;
        endcase
      end
      if (points.valid && points.ready) begin
        fold_point(points.point_x, points.point_y, points.last_point);
        points_taken = points_taken + 1;
      end
      if (result.valid && result.ready) check_summary();
    end
    summaries_due <= due_summaries.size();
  end

endmodule

### tb/nearest_point_and_path_length_unit_tb.sv
// testbench top: drives point runs and query writes, paces the result side, gives the verdict
module nearest_point_and_path_length_unit_tb;
  import nppl_pkg::*;

  // the last point of a run needs up to two root passes; SETTLE_CYCLES covers them with margin
  localparam int SETTLE_CYCLES = 64;
  // cycle limit for the whole test, set above the slowest legal run (every gap and stall at its longest)
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int RANDOM_POINTS = 600;

  localparam logic signed [COORD_BITS-1:0] C_MIN = 16'h8000;
  localparam logic signed [COORD_BITS-1:0] C_MAX = 16'h7fff;

  typedef enum int {STYLE_WIDE, STYLE_NEAR, STYLE_CORNER, STYLE_WALK} point_style_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_QUERY_X;
  logic [COORD_BITS-1:0]     cfg_data  = '0;

  nppl_point_if  points_ch ();
  nppl_result_if result_ch ();

  int     mismatches, summaries_due, points_taken, summaries_taken;
  int     query_settings;
  longint cycle_count;
  bit     gaps_on, stalls_on;

  // query currently loaded, so near-query runs can aim at it
  logic signed [COORD_BITS-1:0] query_x_now, query_y_now;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nearest_point_and_path_length_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .points    (points_ch),
    .result    (result_ch)
  );

  nppl_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .points          (points_ch),
    .result          (result_ch),
    .mismatches      (mismatches),
    .summaries_due   (summaries_due),
    .points_taken    (points_taken),
    .summaries_taken (summaries_taken)
  );

  // idle cycles before a point beat: mostly none or a few, now and then a long hole
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // short runs dominate so many summaries come back; a few longer ones stretch the sums
  function automatic int pick_run_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 1;
    if (r < 70) return $urandom_range(2, 6);
    return $urandom_range(7, 30);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_corner();
    case ($urandom_range(4))
      0:       return C_MIN;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return C_MAX;
    endcase
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_coord(
      input point_style_t style, input logic signed [COORD_BITS-1:0] around,
      input logic signed [COORD_BITS-1:0] prev);
    logic signed [COORD_BITS-1:0] step;
    case (style)
      STYLE_NEAR: begin
        // a few counts off the query: lots of equal distances and near misses
        step = COORD_BITS'($urandom_range(16));
        return around + step - 16'sd8;
      end
      STYLE_CORNER: return pick_corner();
      STYLE_WALK: begin
        step = COORD_BITS'($urandom_range(64));
        return prev + step - 16'sd32;
      end
      default: return COORD_BITS'($urandom_range(16'hffff));
    endcase
  endfunction

  // both query registers, x then y on consecutive edges; block is idle here
  task automatic set_query(input logic signed [COORD_BITS-1:0] qx,
                           input logic signed [COORD_BITS-1:0] qy);
    cfg_write <= 1'b1;
    cfg_index <= REG_QUERY_X;
    cfg_data  <= qx;
    @(posedge clk);
    cfg_index <= REG_QUERY_Y;
    cfg_data  <= qy;
    @(posedge clk);
    cfg_write <= 1'b0;
    query_x_now = qx;
    query_y_now = qy;
    query_settings++;
  endtask

  // one point beat; valid stays up after the handshake in case the next beat follows at once
  task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      points_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    points_ch.valid      <= 1'b1;
    points_ch.point_x    <= x;
    points_ch.point_y    <= y;
    points_ch.last_point <= last;
    do @(posedge clk); while (!(points_ch.valid && points_ch.ready));
  endtask

  task automatic send_run(input int n, input point_style_t style);
    logic signed [COORD_BITS-1:0] x, y;
    x = query_x_now;
    y = query_y_now;
    for (int i = 0; i < n; i++) begin
      x = pick_coord(style, query_x_now, x);
      y = pick_coord(style, query_y_now, y);
      send_point(x, y, i == n - 1);
    end
  endtask

  // stop sending and wait until every closed run has come back, then let the unit settle
  task automatic drain();
    points_ch.valid <= 1'b0;
    @(posedge clk);
    while (summaries_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: ready held in random stretches, or solidly high when stalls are off
  initial begin : result_pacing
    int hold, r;
    hold = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!stalls_on) begin
        result_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 60) begin
          result_ch.ready <= 1'b1;
          hold = $urandom_range(0, 4);
        end else if (r < 95) begin
          result_ch.ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          result_ch.ready <= 1'b0;
          hold = $urandom_range(20, 60);
        end
      end
    end
  end

  // cycle counter: a hang or a lost result ends here
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("no progress after %0d cycles, %0d results outstanding", cycle_count,
             summaries_due);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int           sent, next_query, n;
    point_style_t style;
    points_ch.valid      <= 1'b0;
    points_ch.point_x    <= '0;
    points_ch.point_y    <= '0;
    points_ch.last_point <= 1'b0;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    query_settings = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed runs, back to back with no idling
    set_query(16'sd0, 16'sd0);
    // single point run: short status, zero length
    send_point(16'sd5, -16'sd7, 1'b1);
    // three points all at distance 5: the first keeps the win
    send_point(16'sd3, 16'sd4, 1'b0);
    send_point(-16'sd4, 16'sd3, 1'b0);
    send_point(16'sd0, -16'sd5, 1'b1);
    // later point strictly nearer, lands exactly on the query
    send_point(16'sd1, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
    // repeated point: zero length segment
    send_point(16'sd100, 16'sd100, 1'b0);
    send_point(16'sd100, 16'sd100, 1'b0);
    send_point(-16'sd100, -16'sd100, 1'b1);
    drain();

    // query in one corner, points across the whole plane
    set_query(C_MIN, C_MIN);
    send_point(C_MAX, C_MAX, 1'b1);
    send_point(C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MAX, 1'b0);
    send_point(C_MAX, C_MIN, 1'b1);
    drain();

    set_query(C_MAX, C_MIN);
    send_point(C_MIN, C_MAX, 1'b0);
    send_point(-16'sd1, -16'sd1, 1'b0);
    send_point(C_MAX, C_MIN, 1'b1);
    drain();

    // random runs with idling on both sides; the query moves every hundred points or so
    sent = 0;
    next_query = 0;
    while (sent < RANDOM_POINTS) begin
      if (sent >= next_query) begin
        drain();
        if ($urandom_range(1)) begin
          set_query(COORD_BITS'($urandom_range(16'hffff)),
                    COORD_BITS'($urandom_range(16'hffff)));
        end else begin
          set_query(pick_corner(), pick_corner());
        end
        next_query = sent + $urandom_range(60, 140);
        // some stretches run with no idling at all
        gaps_on   = $urandom_range(3) != 0;
        stalls_on = $urandom_range(3) != 0;
      end
      n = pick_run_len();
      style = point_style_t'($urandom_range(3));
      send_run(n, style);
      sent += n;
      // now and then hold off until the unit has handed back everything
      if ($urandom_range(19) == 0) drain();
    end
    drain();

    // capacity: a run that just fills it, one that overflows (last two points dropped),
    // then a short run to see the drop flag cleared
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    set_query(COORD_BITS'($urandom_range(16'hffff)), COORD_BITS'($urandom_range(16'hffff)));
    send_run(MAX_POINTS, STYLE_WIDE);
    send_run(MAX_POINTS + 2, STYLE_WIDE);
    send_run(3, STYLE_NEAR);
    drain();

    $display("covered %0d point beats and %0d result beats under %0d query settings",
             points_taken, summaries_taken, query_settings);
    $display("runs ranged from a single point to past capacity, query at the corners too");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
rtl/nppl_pkg.sv
rtl/nppl_if.sv
rtl/nppl_root.sv
rtl/nearest_point_and_path_length_unit.sv
rtl/nppl_checker.sv
tb/nppl_checker.sv
tb/nearest_point_and_path_length_unit_tb.sv
